[src/pileup_allele_fraction_filter_core_defines.svh]
// Assertion macros for the pileup allele fraction filter.
// The macros expect clk_i and rst_ni in the scope where they are used.
`ifndef PILEUP_ALLELE_FRACTION_FILTER_CORE_DEFINES_SVH
`define PILEUP_ALLELE_FRACTION_FILTER_CORE_DEFINES_SVH

// General property, checked on every rising clock edge outside reset.
`define PAFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define PAFC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/pafc_pkg.sv]
`default_nettype none

package pafc_pkg;

  // Width of the per-column base counters and of the kept-base counter.
  localparam int unsigned CountWidth = 16;
  // Width at which counters are compared against 16-bit thresholds.
  localparam int unsigned CmpWidth = (CountWidth > 16) ? CountWidth : 16;
  // Fraction bounds are unsigned Q1.16: one integer bit and 16 fraction bits.
  localparam int unsigned FracWidth = 17;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdWidth = FracWidth + CountWidth;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 17;

  typedef logic [CountWidth-1:0]    count_t;
  typedef logic [CmpWidth-1:0]      cmp_t;
  typedef logic [ProdWidth-1:0]     prod_t;
  typedef logic [15:0]              field16_t;
  typedef logic [1:0]               base_idx_t;
  typedef logic [QueueCntWidth-1:0] qcount_t;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegMinDepth    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegMinMapQual  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegMinBaseQual = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegMinFraction = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegMaxFraction = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegMinAltCount = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegStrandMode  = 3'd6;

  // Strand filter codes; the unused code behaves like both strands.
  localparam logic [1:0] StrandBoth    = 2'd0;
  localparam logic [1:0] StrandFwdOnly = 2'd1;
  localparam logic [1:0] StrandRevOnly = 2'd2;

  typedef struct packed {
    logic [30:0] position;
    logic [7:0]  ref_char;
    logic [15:0] column_depth;
    logic        is_deletion;
    logic        is_ref_skip;
    logic [7:0]  mapping_quality;
    logic        is_reverse;
    logic [7:0]  base_quality;
    logic [3:0]  base_code;
    logic        last_read;
  } in_t;

  typedef struct packed {
    logic [30:0] site_position;
    logic [15:0] total_depth;
    logic [15:0] alt_depth;
  } out_t;

  typedef struct packed {
    logic [15:0]          depth_floor;
    logic [7:0]           min_mapping_quality;
    logic [7:0]           min_base_quality;
    logic [FracWidth-1:0] min_fraction;
    logic [FracWidth-1:0] max_fraction;
    logic [15:0]          min_alt_count;
    logic [1:0]           strand_sel;
  } cfg_t;

  // One classified read as it waits between the front and the back.
  typedef struct packed {
    logic [30:0] position;
    logic        counted;
    base_idx_t   base_idx;
    logic        last_read;
    logic        ref_ok;
    base_idx_t   ref_idx;
    logic        depth_ok;
  } qentry_t;

  typedef struct packed {
    qcount_t count;
    logic    full;
    logic    empty;
  } qstatus_t;

endpackage

`default_nettype wire

[src/pafc_cfg.sv]
`default_nettype none

module pafc_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pafc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire logic [pafc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output pafc_pkg::cfg_t                           cfg_o
);

  pafc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_floor         <= 16'd10;
      cfg_q.min_mapping_quality <= 8'd20;
      cfg_q.min_base_quality    <= 8'd20;
      cfg_q.min_fraction        <= 17'd13107;
      cfg_q.max_fraction        <= 17'd45875;
      cfg_q.min_alt_count       <= 16'd2;
      cfg_q.strand_sel          <= pafc_pkg::StrandBoth;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pafc_pkg::RegMinDepth:    cfg_q.depth_floor         <= cfg_data_i[15:0];
        pafc_pkg::RegMinMapQual:  cfg_q.min_mapping_quality <= cfg_data_i[7:0];
        pafc_pkg::RegMinBaseQual: cfg_q.min_base_quality    <= cfg_data_i[7:0];
        pafc_pkg::RegMinFraction: cfg_q.min_fraction        <= cfg_data_i[16:0];
        pafc_pkg::RegMaxFraction: cfg_q.max_fraction        <= cfg_data_i[16:0];
        pafc_pkg::RegMinAltCount: cfg_q.min_alt_count       <= cfg_data_i[15:0];
        pafc_pkg::RegStrandMode:  cfg_q.strand_sel          <= cfg_data_i[1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/pafc_front.sv]
`default_nettype none

module pafc_front (
  input  wire logic               in_valid_i,
  input  wire pafc_pkg::in_t      in_data_i,
  output logic                    in_stall_o,
  input  wire pafc_pkg::cfg_t     cfg_i,
  input  wire pafc_pkg::qstatus_t q_status_i,
  output logic                    push_o,
  output pafc_pkg::qentry_t       entry_o
);

  localparam logic [3:0] CodeA = 4'd1;
  localparam logic [3:0] CodeC = 4'd2;
  localparam logic [3:0] CodeG = 4'd4;
  localparam logic [3:0] CodeT = 4'd8;

  localparam logic [7:0] CharUpA = "A";
  localparam logic [7:0] CharLoA = "a";
  localparam logic [7:0] CharUpC = "C";
  localparam logic [7:0] CharLoC = "c";
  localparam logic [7:0] CharUpG = "G";
  localparam logic [7:0] CharLoG = "g";
  localparam logic [7:0] CharUpT = "T";
  localparam logic [7:0] CharLoT = "t";

  logic                strand_ok;
  logic                keep;
  logic                code_ok;
  pafc_pkg::base_idx_t code_idx;
  logic                ref_ok;
  pafc_pkg::base_idx_t ref_idx;

  always_comb begin
    unique case (cfg_i.strand_sel)
      pafc_pkg::StrandFwdOnly: strand_ok = !in_data_i.is_reverse;
      pafc_pkg::StrandRevOnly: strand_ok = in_data_i.is_reverse;
      default:                 strand_ok = 1'b1;
    endcase

    keep = !in_data_i.is_deletion && !in_data_i.is_ref_skip && strand_ok &&
           (in_data_i.mapping_quality >= cfg_i.min_mapping_quality) &&
           (in_data_i.base_quality >= cfg_i.min_base_quality);

    code_ok = 1'b1;
    unique case (in_data_i.base_code)
      CodeA:   code_idx = 2'd0;
      CodeC:   code_idx = 2'd1;
      CodeG:   code_idx = 2'd2;
      CodeT:   code_idx = 2'd3;
      default: begin
        code_idx = 2'd0;
        code_ok  = 1'b0;
      end
    endcase

    ref_ok = 1'b1;
    unique case (in_data_i.ref_char)
      CharUpA, CharLoA: ref_idx = 2'd0;
      CharUpC, CharLoC: ref_idx = 2'd1;
      CharUpG, CharLoG: ref_idx = 2'd2;
      CharUpT, CharLoT: ref_idx = 2'd3;
      default: begin
        ref_idx = 2'd0;
        ref_ok  = 1'b0;
      end
    endcase
  end

  assign entry_o.position  = in_data_i.position;
  assign entry_o.counted   = keep && code_ok;
  assign entry_o.base_idx  = code_idx;
  assign entry_o.last_read = in_data_i.last_read;
  assign entry_o.ref_ok    = ref_ok;
  assign entry_o.ref_idx   = ref_idx;
  assign entry_o.depth_ok  = in_data_i.column_depth >= cfg_i.depth_floor;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

`default_nettype wire

[src/pafc_queue.sv]
`default_nettype none

module pafc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire pafc_pkg::qentry_t  entry_i,
  input  wire logic               pop_i,
  output pafc_pkg::qentry_t       entry_o,
  output pafc_pkg::qstatus_t      status_o
);

  typedef logic [pafc_pkg::QueuePtrWidth-1:0] ptr_t;

  pafc_pkg::qentry_t mem_q [pafc_pkg::QueueDepth];
  ptr_t              wr_ptr_q, wr_ptr_d;
  ptr_t              rd_ptr_q, rd_ptr_d;
  pafc_pkg::qcount_t count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ptr_t'(pafc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + ptr_t'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ptr_t'(pafc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + ptr_t'(1);
    end
    count_d = count_q + pafc_pkg::qcount_t'(push_i) - pafc_pkg::qcount_t'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.full  = count_q == pafc_pkg::qcount_t'(pafc_pkg::QueueDepth);
  assign status_o.empty = count_q == '0;

endmodule

`default_nettype wire

[src/pafc_back.sv]
`default_nettype none

module pafc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pafc_pkg::cfg_t     cfg_i,
  input  wire pafc_pkg::qstatus_t q_status_i,
  input  wire pafc_pkg::qentry_t  entry_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pafc_pkg::out_t          out_data_o
);

  logic advance;
  logic pop;

  // Column counters.
  pafc_pkg::count_t cnt_q [4];
  pafc_pkg::count_t cnt_new [4];
  pafc_pkg::count_t kept_q, kept_new;

  // Evaluation stage 1: snapshot of a finished column.
  logic                e1_v_q;
  pafc_pkg::count_t    e1_cnt_q [4];
  pafc_pkg::count_t    e1_kept_q;
  logic [30:0]         e1_pos_q;
  logic                e1_ref_ok_q;
  pafc_pkg::base_idx_t e1_ref_idx_q;
  logic                e1_depth_ok_q;

  // Evaluation stage 2: alternate count and threshold checks.
  pafc_pkg::count_t    alt;
  logic                pre_ok;
  logic                e2_v_q;
  pafc_pkg::count_t    e2_alt_q;
  pafc_pkg::count_t    e2_kept_q;
  logic [30:0]         e2_pos_q;
  logic                e2_ok_q;

  // Evaluation stage 3: fraction bound products.
  logic                e3_v_q;
  pafc_pkg::prod_t     e3_lo_q, e3_hi_q;
  pafc_pkg::count_t    e3_alt_q;
  pafc_pkg::count_t    e3_kept_q;
  logic [30:0]         e3_pos_q;
  logic                e3_ok_q;

  pafc_pkg::prod_t     alt_scaled;
  logic                pass;

  logic                out_valid_q;
  pafc_pkg::out_t      out_data_q;

  // The whole back end moves together unless a finished result is stuck.
  assign advance = !out_valid_q || !out_stall_i;
  assign pop     = !q_status_i.empty && advance;
  assign pop_o   = pop;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (entry_i.counted && (entry_i.base_idx == pafc_pkg::base_idx_t'(i)) &&
          (cnt_q[i] != '1)) begin
        cnt_new[i] = cnt_q[i] + pafc_pkg::count_t'(1);
      end else begin
        cnt_new[i] = cnt_q[i];
      end
    end
    if (entry_i.counted && (kept_q != '1)) begin
      kept_new = kept_q + pafc_pkg::count_t'(1);
    end else begin
      kept_new = kept_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
      kept_q <= '0;
    end else if (pop) begin
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= entry_i.last_read ? '0 : cnt_new[i];
      end
      kept_q <= entry_i.last_read ? '0 : kept_new;
    end
  end

  always_comb begin
    alt = '0;
    for (int i = 0; i < 4; i++) begin
      if ((pafc_pkg::base_idx_t'(i) != e1_ref_idx_q) && (e1_cnt_q[i] > alt)) begin
        alt = e1_cnt_q[i];
      end
    end
    pre_ok = e1_depth_ok_q && e1_ref_ok_q && (e1_kept_q != '0) &&
             (pafc_pkg::cmp_t'(e1_kept_q) >= pafc_pkg::cmp_t'(cfg_i.depth_floor)) &&
             (pafc_pkg::cmp_t'(alt) >= pafc_pkg::cmp_t'(cfg_i.min_alt_count));
  end

  assign alt_scaled = pafc_pkg::prod_t'(e3_alt_q) << pafc_pkg::FracBits;
  assign pass = e3_ok_q && (alt_scaled >= e3_lo_q) && (alt_scaled <= e3_hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q      <= 1'b0;
      e2_v_q      <= 1'b0;
      e3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      e1_v_q      <= pop && entry_i.last_read;
      e2_v_q      <= e1_v_q;
      e3_v_q      <= e2_v_q;
      out_valid_q <= e3_v_q && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        e1_cnt_q[i] <= cnt_new[i];
      end
      e1_kept_q     <= kept_new;
      e1_pos_q      <= entry_i.position;
      e1_ref_ok_q   <= entry_i.ref_ok;
      e1_ref_idx_q  <= entry_i.ref_idx;
      e1_depth_ok_q <= entry_i.depth_ok;

      e2_alt_q  <= alt;
      e2_kept_q <= e1_kept_q;
      e2_pos_q  <= e1_pos_q;
      e2_ok_q   <= pre_ok;

      e3_lo_q   <= pafc_pkg::prod_t'(cfg_i.min_fraction) * pafc_pkg::prod_t'(e2_kept_q);
      e3_hi_q   <= pafc_pkg::prod_t'(cfg_i.max_fraction) * pafc_pkg::prod_t'(e2_kept_q);
      e3_alt_q  <= e2_alt_q;
      e3_kept_q <= e2_kept_q;
      e3_pos_q  <= e2_pos_q;
      e3_ok_q   <= e2_ok_q;

      out_data_q.site_position <= e3_pos_q;
      out_data_q.total_depth   <= pafc_pkg::field16_t'(e3_kept_q);
      out_data_q.alt_depth     <= pafc_pkg::field16_t'(e3_alt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[src/pileup_allele_fraction_filter_core.sv]
`default_nettype none

// Pileup column allele fraction filter. Reads of one pileup column arrive one
// item per cycle while in_stall_o is low, the final read of a column marked by
// last_read; the column fields (position, reference base, depth) are taken
// from that final item. The block sustains one read per cycle while the output
// is not stalled: the rate is set by the update of the four base counters and
// the kept-base counter in the back end. A column that passes every filter
// yields one result item through the queue, the three evaluation stages and the
// output register; columns that fail yield nothing. Counters saturate and clear
// after every column. Configuration writes are always ready and should only be
// issued while the block is idle.

`include "pileup_allele_fraction_filter_core_defines.svh"

module pileup_allele_fraction_filter_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire pafc_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output pafc_pkg::out_t                           out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pafc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire logic [pafc_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  pafc_pkg::cfg_t     cfg;
  pafc_pkg::qstatus_t q_status;
  pafc_pkg::qentry_t  q_in;
  pafc_pkg::qentry_t  q_out;
  logic               q_push;
  logic               q_pop;

  // Configuration registers, shared by the front and the back.
  pafc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The front applies the read filters and decodes the base and reference
  // codes, so each queued item only carries what the counters need.
  pafc_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .q_status_i (q_status),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  // A short queue lets the input keep flowing while a result waits.
  pafc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_in),
    .pop_i    (q_pop),
    .entry_o  (q_out),
    .status_o (q_status)
  );

  // The back counts bases and runs the column test in a short pipeline.
  pafc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_status_i  (q_status),
    .entry_i     (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The back never takes an item from an empty queue.
  `PAFC_ASSERT_IMPLIES(PopNeedsEntry, q_pop, !q_status.empty, "queue popped while empty")

  // A waiting result freezes the back end, so nothing leaves the queue.
  `PAFC_ASSERT_IMPLIES(StalledResultHoldsBack, out_valid_o && out_stall_i, !q_pop,
    "queue popped while a result is stalled")

  // A push without a pop grows the occupancy by exactly one.
  `PAFC_ASSERT(QueueCountTracksPush,
    (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + pafc_pkg::qcount_t'(1)),
    "queue occupancy did not grow on push")

endmodule

`default_nettype wire
